@@ rtl/mexp_pkg.sv @@
// ----------------------------------------------------------------------------
// mexp_pkg
// Shared constants of the modular exponentiation core.
// ----------------------------------------------------------------------------
package mexp_pkg;

  // configuration register index width and register map
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_EXPONENT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MODULUS  = 2'd1;

endpackage

@@ rtl/modular_exponentiation_core.sv @@
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// Computes base_value^exponent mod modulus by right-to-left square-and-multiply.
// ----------------------------------------------------------------------------
// One bit-serial modular multiplier does all the work, taking one multiplier
// bit per cycle. An item first has its base reduced modulo the modulus by
// that multiplier, then takes one multiply per set exponent bit and one
// squaring per exponent bit below the highest set bit. A finished result
// waits in S_DONE while the output register is held. A modulus below two
// gives zero without any multiply, a zero exponent gives one. Items are
// handled one at a time; the next item may be taken while a finished result
// waits in the output register. Exponent and modulus are to be written
// through the config port by the user while the core is idle; the core
// itself does not enforce this. Writes to other indexes are ignored.
module modular_exponentiation_core
  import mexp_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // config write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_addr_i,
  input  logic [DATA_WIDTH-1:0] cfg_data_i,
  // input channel
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [DATA_WIDTH-1:0] base_value_i,
  // output channel
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [DATA_WIDTH-1:0] power_result_o
);

  localparam int unsigned CntW = $clog2(DATA_WIDTH);
  localparam int unsigned SumW = DATA_WIDTH + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_MUL,
    S_SQR,
    S_DONE
  } state_e;

  state_e                state_q;
  logic [DATA_WIDTH-1:0] exp_cfg_q;
  logic [DATA_WIDTH-1:0] mod_q;
  logic [DATA_WIDTH-1:0] exp_q;     // remaining exponent bits, lsb first
  logic [DATA_WIDTH-1:0] base_q;
  logic [DATA_WIDTH-1:0] res_q;
  logic [DATA_WIDTH-1:0] a_q;       // addend of the multiplier
  logic [DATA_WIDTH-1:0] b_q;       // multiplier bits, msb out first
  logic [DATA_WIDTH-1:0] acc_q;
  logic [CntW-1:0]       cnt_q;
  logic                  out_valid_q;
  logic [DATA_WIDTH-1:0] out_data_q;

  logic [SumW-1:0]       sum;
  logic [SumW-1:0]       mod1;
  logic [SumW-1:0]       mod2;
  logic [SumW-1:0]       red;
  logic [DATA_WIDTH-1:0] acc_nx;
  logic [DATA_WIDTH-1:0] pick_res;
  logic                  mul_last;
  logic                  mod_small;
  logic                  out_free;

  assign cfg_ready_o    = 1'b1;
  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign power_result_o = out_data_q;

  assign mul_last  = (cnt_q == CntW'(DATA_WIDTH - 1));
  assign mod_small = (mod_q[DATA_WIDTH-1:1] == '0);
  assign out_free  = !out_valid_q || out_ready_i;
  assign pick_res  = (state_q == S_REDUCE) ? DATA_WIDTH'(1) : res_q;

  // one shift-and-add step: acc = (2*acc + bit*a) mod m, sum stays below 3m
  always_comb begin
    mod1 = {2'b00, mod_q};
    mod2 = {1'b0, mod_q, 1'b0};
    sum  = {1'b0, acc_q, 1'b0} + (b_q[DATA_WIDTH-1] ? {2'b00, a_q} : '0);
    priority if (sum >= mod2) begin
      red = sum - mod2;
    end else if (sum >= mod1) begin
      red = sum - mod1;
    end else begin
      red = sum;
    end
    acc_nx = red[DATA_WIDTH-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      exp_cfg_q   <= '0;
      mod_q       <= DATA_WIDTH'(2);
      exp_q       <= '0;
      base_q      <= '0;
      res_q       <= '0;
      a_q         <= '0;
      b_q         <= '0;
      acc_q       <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      cnt_q       <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_addr_i == CFG_EXPONENT) begin
          exp_cfg_q <= cfg_data_i;
        end else if (cfg_addr_i == CFG_MODULUS) begin
          mod_q <= cfg_data_i;
        end
      end

      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            exp_q <= exp_cfg_q;
            acc_q <= '0;
            cnt_q <= '0;
            if (mod_small) begin
              res_q   <= '0;
              state_q <= S_DONE;
            end else begin
              // base mod m is the product 1 * base
              a_q     <= DATA_WIDTH'(1);
              b_q     <= base_value_i;
              state_q <= S_REDUCE;
            end
          end
        end

        S_REDUCE, S_SQR, S_MUL: begin
          acc_q <= acc_nx;
          b_q   <= b_q << 1;
          cnt_q <= cnt_q + 1'b1;
          if (mul_last) begin
            acc_q <= '0;
            cnt_q <= '0;
            if (state_q == S_MUL) begin
              res_q <= acc_nx;
              exp_q <= exp_q >> 1;
              if (exp_q[DATA_WIDTH-1:1] == '0) begin
                state_q <= S_DONE;
              end else begin
                a_q     <= base_q;
                b_q     <= base_q;
                state_q <= S_SQR;
              end
            end else begin
              base_q <= acc_nx;
              if (state_q == S_REDUCE) begin
                res_q <= DATA_WIDTH'(1);
              end
              if (exp_q == '0) begin
                state_q <= S_DONE;
              end else if (exp_q[0]) begin
                a_q     <= acc_nx;
                b_q     <= pick_res;
                state_q <= S_MUL;
              end else begin
                exp_q   <= exp_q >> 1;
                a_q     <= acc_nx;
                b_q     <= acc_nx;
                state_q <= S_SQR;
              end
            end
          end
        end

        S_DONE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_q;
            state_q     <= S_IDLE;
          end
        end

        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule
